FILE: hw/rtl/midi_pca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI polyphonic channel allocator package
// Field widths, MIDI command codes, result kinds and register indexes.
// ----------------------------------------------------------------------------
package midi_pca_pkg;

   // Field widths
   localparam int STATUS_W   = 8;
   localparam int DATA_W     = 7;
   localparam int COUNT_W    = 2;
   localparam int KIND_W     = 3;
   localparam int CHAN_W     = 4;
   localparam int POLY_W     = 5;
   localparam int MASK_W     = 16;
   localparam int CSR_DATA_W = 16;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [3:0]        cmd_type;

   // Upper status nibble
   localparam cmd_type CMD_NOTE_OFF   = 4'h8;
   localparam cmd_type CMD_NOTE_ON    = 4'h9;
   localparam cmd_type CMD_POLY_AT    = 4'hA;
   localparam cmd_type CMD_CONTROL    = 4'hB;
   localparam cmd_type CMD_PROGRAM    = 4'hC;
   localparam cmd_type CMD_CHAN_AT    = 4'hD;
   localparam cmd_type CMD_SYSTEM     = 4'hF;

   localparam logic [STATUS_W-1:0] STATUS_SYSTEM_RESET = 8'hFF;
   localparam logic [DATA_W-1:0]   CTRL_ALL_NOTES_OFF  = 7'd123;

   // Result kinds
   localparam kind_type KIND_NOTE_ON  = 3'd0;
   localparam kind_type KIND_NOTE_OFF = 3'd1;
   localparam kind_type KIND_CONTROL  = 3'd2;
   localparam kind_type KIND_PROGRAM  = 3'd3;
   localparam kind_type KIND_POLY_AT  = 3'd4;
   localparam kind_type KIND_CHAN_AT  = 3'd5;
   localparam kind_type KIND_RESET    = 3'd6;

   // Register indexes
   localparam logic CSR_MAX_POLYPHONY = 1'b0;
   localparam logic CSR_CHANNEL_MASK  = 1'b1;

endpackage

FILE: hw/rtl/midi_polyphonic_channel_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI polyphonic channel allocator
// Maps incoming notes onto free output channels and re-sends channel messages.
// ----------------------------------------------------------------------------
// Timing: a note or poly aftertouch result is registered from ST_LOOKUP once the
//    output register is free; control and program from ST_BCAST; channel
//    aftertouch from ST_SCAN_EMIT after ST_SCAN_RD reads each mapped note. A new
//    request is taken only in ST_IDLE, so each message finishes before the next;
//    control and program copy once per allocatable channel, aftertouch per mapped note.
// Reset: synchronous; clears the note valid bits and busy mask.
module midi_polyphonic_channel_allocator #(
   parameter int NOTE_COUNT    = 128,
   parameter int CHANNEL_COUNT = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [midi_pca_pkg::STATUS_W-1:0]     req_status_byte,
   input  logic [midi_pca_pkg::DATA_W-1:0]       req_data_one,
   input  logic [midi_pca_pkg::DATA_W-1:0]       req_data_two,
   input  logic [midi_pca_pkg::COUNT_W-1:0]      req_byte_count,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [midi_pca_pkg::KIND_W-1:0]       rsp_out_kind,
   output logic [midi_pca_pkg::CHAN_W-1:0]       rsp_out_channel,
   output logic [midi_pca_pkg::DATA_W-1:0]       rsp_out_first,
   output logic [midi_pca_pkg::DATA_W-1:0]       rsp_out_second,
   output logic                                  rsp_out_last,
   // configuration
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [midi_pca_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NW = $clog2(NOTE_COUNT);
   localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int PW = $clog2(CHANNEL_COUNT + 1);
   localparam int DW = midi_pca_pkg::DATA_W;
   localparam int YW = midi_pca_pkg::POLY_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_LOOKUP    = 3'd1;
   localparam logic [2:0] ST_BCAST     = 3'd2;
   localparam logic [2:0] ST_SCAN_RD   = 3'd3;
   localparam logic [2:0] ST_SCAN_EMIT = 3'd4;

   // Decoded operations
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_RESET    = 3'd1;
   localparam logic [2:0] OP_NOTE_ON  = 3'd2;
   localparam logic [2:0] OP_NOTE_OFF = 3'd3;
   localparam logic [2:0] OP_CONTROL  = 3'd4;
   localparam logic [2:0] OP_PROGRAM  = 3'd5;
   localparam logic [2:0] OP_POLY_AT  = 3'd6;
   localparam logic [2:0] OP_CHAN_AT  = 3'd7;

   // Control state
   logic [2:0]                state_ff, state_in;
   logic [2:0]                op_ff, op_in;
   logic [NOTE_COUNT-1:0]     valid_ff, valid_in;
   logic [CHANNEL_COUNT-1:0]  busy_ff, busy_in;
   logic [YW-1:0]             poly_ff, poly_in;
   logic [midi_pca_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [CW-1:0]             chan_idx_ff, chan_idx_in;
   logic [NW-1:0]             note_idx_ff, note_idx_in;
   logic [PW-1:0]             sent_ff, sent_in;
   logic [PW-1:0]             total_ff, total_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [DW-1:0]             d1_ff, d2_ff;
   logic [midi_pca_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [midi_pca_pkg::CHAN_W-1:0] rsp_chan_ff;
   logic [DW-1:0]             rsp_first_ff, rsp_second_ff;
   logic                      rsp_last_ff;

   // Note map memory: channel per note, valid bits held in valid_ff
   logic [CW-1:0]             map_mem [NOTE_COUNT];
   logic [CW-1:0]             mem_rdata_ff;
   logic                      mem_re, mem_we;
   logic [NW-1:0]             mem_raddr;
   logic [CW-1:0]             mem_wdata;

   // Datapath helpers
   logic                      accept, out_free;
   logic [3:0]                req_cmd;
   logic [3:0]                req_chan;
   logic                      note_in_range, mapped;
   logic [CHANNEL_COUNT-1:0]  free_vec;
   logic                      free_any;
   logic [CW-1:0]             free_ch;
   logic [PW-1:0]             busy_count;
   logic [YW-1:0]             clamp_val;

   // Emit bundle
   logic                      emit_en;
   logic [midi_pca_pkg::KIND_W-1:0] emit_kind;
   logic [CW-1:0]             emit_ch;
   logic [midi_pca_pkg::CHAN_W-1:0] emit_ch_ext;
   logic [DW-1:0]             emit_first, emit_second;
   logic                      emit_last;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_cmd   = req_status_byte[7:4];
   assign req_chan  = req_status_byte[3:0];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_out_first   = rsp_first_ff;
   assign rsp_out_second  = rsp_second_ff;
   assign rsp_out_last    = rsp_last_ff;

   // Decode the incoming message
   always_comb begin
      op_in = OP_NONE;
      if (req_byte_count != 2'd0) begin
         if (req_cmd == midi_pca_pkg::CMD_SYSTEM) begin
            if (req_status_byte == midi_pca_pkg::STATUS_SYSTEM_RESET) begin
               op_in = OP_RESET;
            end
         end else if (req_status_byte[7] && mask_ff[req_chan]) begin
            case (req_cmd)
               midi_pca_pkg::CMD_NOTE_ON: begin
                  if (req_byte_count == 2'd3) begin
                     op_in = (req_data_two == '0) ? OP_NOTE_OFF : OP_NOTE_ON;
                  end
               end
               midi_pca_pkg::CMD_NOTE_OFF: begin
                  if (req_byte_count >= 2'd2) op_in = OP_NOTE_OFF;
               end
               midi_pca_pkg::CMD_CONTROL: begin
                  if (req_byte_count == 2'd3) op_in = OP_CONTROL;
               end
               midi_pca_pkg::CMD_PROGRAM: begin
                  if (req_byte_count >= 2'd2) op_in = OP_PROGRAM;
               end
               midi_pca_pkg::CMD_POLY_AT: begin
                  if (req_byte_count == 2'd3) op_in = OP_POLY_AT;
               end
               midi_pca_pkg::CMD_CHAN_AT: begin
                  if (req_byte_count >= 2'd2) op_in = OP_CHAN_AT;
               end
               default: op_in = OP_NONE;
            endcase
         end
      end
   end

   // Look up the held note in the map
   assign note_in_range = ({1'b0, d1_ff} < 8'(NOTE_COUNT));
   assign mapped        = note_in_range && valid_ff[d1_ff[NW-1:0]];

   // Find the lowest free channel below the polyphony limit
   always_comb begin
      free_any = 1'b0;
      free_ch  = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         free_vec[i] = !busy_ff[i] && (YW'(i) < poly_ff);
      end
      for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_any = 1'b1;
            free_ch  = CW'(i);
         end
      end
   end

   // Count mapped notes (one busy channel per mapped note)
   always_comb begin
      busy_count = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         busy_count = busy_count + PW'(busy_ff[i]);
      end
   end

   // Clamp the polyphony write
   always_comb begin
      clamp_val = csr_wdata[YW-1:0];
      if (clamp_val > YW'(CHANNEL_COUNT)) clamp_val = YW'(CHANNEL_COUNT);
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      busy_in     = busy_ff;
      chan_idx_in = chan_idx_ff;
      note_idx_in = note_idx_ff;
      sent_in     = sent_ff;
      total_in    = total_ff;
      mem_re      = 1'b0;
      mem_raddr   = req_data_one[NW-1:0];
      mem_we      = 1'b0;
      mem_wdata   = free_ch;
      emit_en     = 1'b0;
      emit_kind   = midi_pca_pkg::KIND_NOTE_ON;
      emit_ch     = mem_rdata_ff;
      emit_first  = d1_ff;
      emit_second = '0;
      emit_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept && op_in != OP_NONE) begin
               mem_re   = 1'b1;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            case (op_ff)
               OP_RESET: begin
                  if (out_free) begin
                     emit_en    = 1'b1;
                     emit_kind  = midi_pca_pkg::KIND_RESET;
                     emit_ch    = '0;
                     emit_first = '0;
                     valid_in   = '0;
                     busy_in    = '0;
                     state_in   = ST_IDLE;
                  end
               end
               OP_NOTE_ON: begin
                  if (mapped) begin
                     if (out_free) begin
                        emit_en     = 1'b1;
                        emit_second = d2_ff;
                        state_in    = ST_IDLE;
                     end
                  end else if (free_any && note_in_range) begin
                     if (out_free) begin
                        emit_en     = 1'b1;
                        emit_ch     = free_ch;
                        emit_second = d2_ff;
                        mem_we      = 1'b1;
                        busy_in[free_ch]          = 1'b1;
                        valid_in[d1_ff[NW-1:0]]   = 1'b1;
                        state_in    = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_NOTE_OFF: begin
                  if (mapped) begin
                     if (out_free) begin
                        emit_en   = 1'b1;
                        emit_kind = midi_pca_pkg::KIND_NOTE_OFF;
                        busy_in[mem_rdata_ff]   = 1'b0;
                        valid_in[d1_ff[NW-1:0]] = 1'b0;
                        state_in  = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_CONTROL, OP_PROGRAM: begin
                  if (op_ff == OP_CONTROL && d1_ff == midi_pca_pkg::CTRL_ALL_NOTES_OFF) begin
                     valid_in = '0;
                     busy_in  = '0;
                  end
                  chan_idx_in = '0;
                  state_in    = (poly_ff != '0) ? ST_BCAST : ST_IDLE;
               end
               OP_POLY_AT: begin
                  if (mapped) begin
                     if (out_free) begin
                        emit_en     = 1'b1;
                        emit_kind   = midi_pca_pkg::KIND_POLY_AT;
                        emit_second = d2_ff;
                        state_in    = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_CHAN_AT: begin
                  note_idx_in = '0;
                  sent_in     = '0;
                  total_in    = busy_count;
                  state_in    = (busy_ff != '0) ? ST_SCAN_RD : ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // Copy control or program change to each allocatable channel
         ST_BCAST: begin
            if (out_free) begin
               emit_en     = 1'b1;
               emit_ch     = chan_idx_ff;
               emit_kind   = (op_ff == OP_CONTROL) ? midi_pca_pkg::KIND_CONTROL
                                                   : midi_pca_pkg::KIND_PROGRAM;
               emit_second = (op_ff == OP_CONTROL) ? d2_ff : '0;
               emit_last   = ((YW'(chan_idx_ff) + YW'(1)) == poly_ff);
               chan_idx_in = chan_idx_ff + CW'(1);
               if (emit_last) state_in = ST_IDLE;
            end
         end

         // Walk the note map; read the channel of each mapped note
         ST_SCAN_RD: begin
            if (valid_ff[note_idx_ff]) begin
               mem_re    = 1'b1;
               mem_raddr = note_idx_ff;
               state_in  = ST_SCAN_EMIT;
            end else if (note_idx_ff == NW'(NOTE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               note_idx_in = note_idx_ff + NW'(1);
            end
         end

         ST_SCAN_EMIT: begin
            if (out_free) begin
               emit_en     = 1'b1;
               emit_kind   = midi_pca_pkg::KIND_CHAN_AT;
               emit_last   = ((sent_ff + PW'(1)) == total_ff);
               sent_in     = sent_ff + PW'(1);
               note_idx_in = note_idx_ff + NW'(1);
               if (emit_last || note_idx_ff == NW'(NOTE_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Polyphony write drops every mapping
      if (csr_we && csr_index == midi_pca_pkg::CSR_MAX_POLYPHONY) begin
         valid_in = '0;
         busy_in  = '0;
      end
   end

   // Configuration registers
   always_comb begin
      poly_in = poly_ff;
      mask_in = mask_ff;
      if (csr_we) begin
         case (csr_index)
            midi_pca_pkg::CSR_MAX_POLYPHONY: poly_in = clamp_val;
            midi_pca_pkg::CSR_CHANNEL_MASK:  mask_in = csr_wdata;
            default: mask_in = mask_ff;
         endcase
      end
   end

   // Widen the emitted channel
   always_comb begin
      emit_ch_ext         = '0;
      emit_ch_ext[CW-1:0] = emit_ch;
   end

   // Load or drain the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NONE;
         valid_ff     <= '0;
         busy_ff      <= '0;
         poly_ff      <= YW'(CHANNEL_COUNT);
         mask_ff      <= '0;
         chan_idx_ff  <= '0;
         note_idx_ff  <= '0;
         sent_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (accept) op_ff <= op_in;
         valid_ff     <= valid_in;
         busy_ff      <= busy_in;
         poly_ff      <= poly_in;
         mask_ff      <= mask_in;
         chan_idx_ff  <= chan_idx_in;
         note_idx_ff  <= note_idx_in;
         sent_ff      <= sent_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         d1_ff <= req_data_one;
         d2_ff <= req_data_two;
      end
      if (emit_en) begin
         rsp_kind_ff   <= emit_kind;
         rsp_chan_ff   <= emit_ch_ext;
         rsp_first_ff  <= emit_first;
         rsp_second_ff <= emit_second;
         rsp_last_ff   <= emit_last;
      end
   end

   // Note map memory
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[d1_ff[NW-1:0]] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= map_mem[mem_raddr];
   end

   // Each mapped note owns exactly one busy channel
   a_map_matches_busy: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == $countones(busy_ff))
      else $error("note map and busy mask disagree");

   // Busy channels never exceed the polyphony limit
   a_busy_within_poly: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) <= poly_ff)
      else $error("more busy channels than polyphony allows");

   // Polyphony stays clamped
   a_poly_clamped: assert property (@(posedge clock) disable iff (reset)
      poly_ff <= YW'(CHANNEL_COUNT))
      else $error("polyphony above channel count");

   // A reset result leaves the map empty
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_en && emit_kind == midi_pca_pkg::KIND_RESET) |=>
         (busy_ff == '0 && valid_ff == '0))
      else $error("reset message left notes mapped");

   // Aftertouch walk never emits past the mapped count
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EMIT) |-> (sent_ff < total_ff))
      else $error("channel aftertouch walk overran");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI polyphonic channel allocator testbench
// Sends MIDI messages through the request port and keeps its own model of
// the note map, the busy channels and both registers. Every response is
// checked field by field against the predicted transaction, with random
// stalls on both ports and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int NOTE_TOTAL    = 128;
   localparam int CHANNEL_TOTAL = 16;
   localparam int PRINT_LIMIT   = 50;

   localparam int STATUS_W   = midi_pca_pkg::STATUS_W;
   localparam int DATA_W     = midi_pca_pkg::DATA_W;
   localparam int COUNT_W    = midi_pca_pkg::COUNT_W;
   localparam int KIND_W     = midi_pca_pkg::KIND_W;
   localparam int CHAN_W     = midi_pca_pkg::CHAN_W;
   localparam int MASK_W     = midi_pca_pkg::MASK_W;
   localparam int CSR_DATA_W = midi_pca_pkg::CSR_DATA_W;

   typedef struct {
      midi_pca_pkg::kind_type kind;
      logic [CHAN_W-1:0]   channel;
      logic [DATA_W-1:0]   first;
      logic [DATA_W-1:0]   second;
      logic                last;
   } midi_event_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [STATUS_W-1:0]   req_status_byte;
   logic [DATA_W-1:0]     req_data_one;
   logic [DATA_W-1:0]     req_data_two;
   logic [COUNT_W-1:0]    req_byte_count;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [KIND_W-1:0]     rsp_out_kind;
   logic [CHAN_W-1:0]     rsp_out_channel;
   logic [DATA_W-1:0]     rsp_out_first;
   logic [DATA_W-1:0]     rsp_out_second;
   logic                  rsp_out_last;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted allocator state
   logic                  note_valid [NOTE_TOTAL];
   logic [CHAN_W-1:0]     note_chan  [NOTE_TOTAL];
   logic [15:0]           busy_mask;
   int                    poly_limit;
   logic [MASK_W-1:0]     listen_mask;

   // Transactions predicted for one message, then queued for the checker
   midi_event_type        routed [CHANNEL_TOTAL];
   int                    routed_count;
   midi_event_type        pending_events [$];
   midi_event_type        expected_event;

   int                    error_count  = 0;
   int                    cycle_count  = 0;
   int                    stall_left   = 0;
   int                    hold_request = 0;
   bit                    steady_flow  = 1'b0;

   midi_polyphonic_channel_allocator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_status_byte (req_status_byte),
      .req_data_one    (req_data_one),
      .req_data_two    (req_data_two),
      .req_byte_count  (req_byte_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_first   (rsp_out_first),
      .rsp_out_second  (rsp_out_second),
      .rsp_out_last    (rsp_out_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic void clear_note_map();
      for (int n = 0; n < NOTE_TOTAL; n++) note_valid[n] = 1'b0;
      busy_mask = '0;
   endfunction

   function automatic void add_event(midi_pca_pkg::kind_type kind, int channel,
                                     logic [DATA_W-1:0] first,
                                     logic [DATA_W-1:0] second);
      if (routed_count < CHANNEL_TOTAL) begin
         routed[routed_count] = '{kind: kind, channel: CHAN_W'(channel),
                                  first: first, second: second, last: 1'b0};
         routed_count++;
      end
   endfunction

   // Free the note's channel and send a note-off on it
   function automatic void release_note(logic [DATA_W-1:0] note);
      if (note_valid[note]) begin
         add_event(midi_pca_pkg::KIND_NOTE_OFF, note_chan[note], note, '0);
         busy_mask[note_chan[note]] = 1'b0;
         note_valid[note] = 1'b0;
      end
   endfunction

   function automatic void route_message(logic [STATUS_W-1:0] status,
                                         logic [DATA_W-1:0] d1,
                                         logic [DATA_W-1:0] d2,
                                         logic [COUNT_W-1:0] count);
      midi_pca_pkg::cmd_type cmd;
      logic    allocated;
      cmd = status[7:4];
      allocated = 1'b0;
      routed_count = 0;
      if (count != 0) begin
         if (cmd == midi_pca_pkg::CMD_SYSTEM) begin
            if (status == midi_pca_pkg::STATUS_SYSTEM_RESET) begin
               clear_note_map();
               add_event(midi_pca_pkg::KIND_RESET, 0, '0, '0);
            end
         end else if (status[7] && listen_mask[status[3:0]]) begin
            case (cmd)
               midi_pca_pkg::CMD_NOTE_ON: begin
                  if (count == 3) begin
                     if (d2 == 0) begin
                        release_note(d1);
                     end else if (note_valid[d1]) begin
                        add_event(midi_pca_pkg::KIND_NOTE_ON, note_chan[d1], d1, d2);
                     end else begin
                        // take the lowest free channel under the limit
                        for (int c = 0; c < poly_limit; c++) begin
                           if (!allocated && !busy_mask[c]) begin
                              allocated     = 1'b1;
                              busy_mask[c]  = 1'b1;
                              note_valid[d1] = 1'b1;
                              note_chan[d1] = CHAN_W'(c);
                              add_event(midi_pca_pkg::KIND_NOTE_ON, c, d1, d2);
                           end
                        end
                     end
                  end
               end
               midi_pca_pkg::CMD_NOTE_OFF: begin
                  if (count >= 2) release_note(d1);
               end
               midi_pca_pkg::CMD_CONTROL: begin
                  if (count == 3) begin
                     if (d1 == midi_pca_pkg::CTRL_ALL_NOTES_OFF) clear_note_map();
                     for (int c = 0; c < poly_limit; c++)
                        add_event(midi_pca_pkg::KIND_CONTROL, c, d1, d2);
                  end
               end
               midi_pca_pkg::CMD_PROGRAM: begin
                  if (count >= 2) begin
                     for (int c = 0; c < poly_limit; c++)
                        add_event(midi_pca_pkg::KIND_PROGRAM, c, d1, '0);
                  end
               end
               midi_pca_pkg::CMD_POLY_AT: begin
                  if (count == 3 && note_valid[d1])
                     add_event(midi_pca_pkg::KIND_POLY_AT, note_chan[d1], d1, d2);
               end
               midi_pca_pkg::CMD_CHAN_AT: begin
                  if (count >= 2) begin
                     for (int n = 0; n < NOTE_TOTAL; n++) begin
                        if (note_valid[n])
                           add_event(midi_pca_pkg::KIND_CHAN_AT, note_chan[n], d1, '0);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      for (int i = 0; i < routed_count; i++) begin
         routed[i].last = (i == routed_count - 1);
         pending_events.insert(pending_events.size(), routed[i]);
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction kind %0d channel %0d",
                                      rsp_out_kind, rsp_out_channel));
         end else begin
            expected_event = pending_events.pop_front();
            check_field("kind", 8'(rsp_out_kind), 8'(expected_event.kind));
            check_field("channel", 8'(rsp_out_channel), 8'(expected_event.channel));
            check_field("first", 8'(rsp_out_first), 8'(expected_event.first));
            check_field("second", 8'(rsp_out_second), 8'(expected_event.second));
            check_field("last", 8'(rsp_out_last), 8'(expected_event.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Stall the response side at random; a requested hold-off overrides
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                 : $urandom_range(15, 40);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_message(input logic [STATUS_W-1:0] status,
                               input logic [DATA_W-1:0] d1,
                               input logic [DATA_W-1:0] d2,
                               input logic [COUNT_W-1:0] count);
      int gap;
      req_valid       <= 1'b1;
      req_status_byte <= status;
      req_data_one    <= d1;
      req_data_two    <= d2;
      req_byte_count  <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      route_message(status, d1, d2, count);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain all predicted transactions, then let the walk finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == midi_pca_pkg::CSR_MAX_POLYPHONY) begin
         poly_limit = (value[4:0] > CHANNEL_TOTAL) ? CHANNEL_TOTAL : int'(value[4:0]);
         clear_note_map();
      end else begin
         listen_mask = value;
      end
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] poly,
                            input logic [CSR_DATA_W-1:0] mask);
      wait_idle();
      write_register(midi_pca_pkg::CSR_MAX_POLYPHONY, poly);
      write_register(midi_pca_pkg::CSR_CHANNEL_MASK, mask);
   endtask

   function automatic logic [3:0] pick_channel();
      logic [3:0] c;
      c = 4'($urandom_range(0, 15));
      if (listen_mask != 0 && $urandom_range(0, 9) < 8) begin
         while (!listen_mask[c]) c = 4'($urandom_range(0, 15));
      end
      return c;
   endfunction

   // Most notes come from one octave so retriggers and note-offs hit
   function automatic logic [DATA_W-1:0] pick_note();
      if ($urandom_range(0, 9) < 7) return DATA_W'(60 + $urandom_range(0, 11));
      return DATA_W'($urandom_range(0, 127));
   endfunction

   task automatic send_random_message();
      int                r;
      logic [3:0]        ch;
      logic [DATA_W-1:0] d2;
      r  = $urandom_range(0, 99);
      ch = pick_channel();
      d2 = DATA_W'($urandom_range(1, 127));
      if (r < 40) begin
         if ($urandom_range(0, 9) == 0) d2 = '0;
         send_message({midi_pca_pkg::CMD_NOTE_ON, ch}, pick_note(), d2, 2'd3);
      end else if (r < 65) begin
         send_message({midi_pca_pkg::CMD_NOTE_OFF, ch}, pick_note(), d2,
                      2'($urandom_range(2, 3)));
      end else if (r < 71) begin
         send_message({midi_pca_pkg::CMD_CONTROL, ch},
                      ($urandom_range(0, 4) == 0) ? midi_pca_pkg::CTRL_ALL_NOTES_OFF
                                                  : DATA_W'($urandom_range(0, 127)),
                      d2, 2'd3);
      end else if (r < 76) begin
         send_message({midi_pca_pkg::CMD_PROGRAM, ch}, DATA_W'($urandom_range(0, 127)),
                      d2, 2'($urandom_range(2, 3)));
      end else if (r < 83) begin
         send_message({midi_pca_pkg::CMD_POLY_AT, ch}, pick_note(), d2, 2'd3);
      end else if (r < 88) begin
         send_message({midi_pca_pkg::CMD_CHAN_AT, ch}, DATA_W'($urandom_range(0, 127)),
                      d2, 2'($urandom_range(2, 3)));
      end else begin
         // random noise: any status, any length
         send_message(STATUS_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 127)),
                      DATA_W'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset values: every channel masked off, full polyphony
   task automatic test_default_state();
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd60, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd5}, 7'd7, 7'd90, 2'd3);
      send_message(midi_pca_pkg::STATUS_SYSTEM_RESET, 7'd0, 7'd0, 2'd1);
   endtask

   task automatic test_directed_cases();
      configure(16'd16, 16'hFFFF);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd0, 7'd127, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd15}, 7'd127, 7'd1, 2'd3);
      // retrigger reuses the channel
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd3}, 7'd0, 7'd64, 2'd3);
      send_message({midi_pca_pkg::CMD_POLY_AT, 4'd1}, 7'd127, 7'd127, 2'd3);
      send_message({midi_pca_pkg::CMD_POLY_AT, 4'd1}, 7'd50, 7'd10, 2'd3);
      send_message({midi_pca_pkg::CMD_CHAN_AT, 4'd2}, 7'd127, 7'd33, 2'd2);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd4}, 7'd0, 7'd127, 2'd3);
      send_message({midi_pca_pkg::CMD_PROGRAM, 4'd9}, 7'd127, 7'd55, 2'd2);
      // short messages are dropped
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd10, 7'd100, 2'd2);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd0}, 7'd1, 7'd1, 2'd2);
      send_message({midi_pca_pkg::CMD_PROGRAM, 4'd0}, 7'd1, 7'd0, 2'd1);
      send_message({midi_pca_pkg::CMD_NOTE_OFF, 4'd0}, 7'd0, 7'd0, 2'd1);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd20, 7'd90, 2'd0);
      // velocity zero frees the note
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd7}, 7'd127, 7'd0, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_OFF, 4'd0}, 7'd99, 7'd0, 2'd2);
      send_message(8'hE0, 7'd0, 7'd64, 2'd3);
      send_message(8'h45, 7'd60, 7'd100, 2'd3);
      send_message(8'hF8, 7'd0, 7'd0, 2'd1);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd64, 7'd80, 2'd3);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd0}, midi_pca_pkg::CTRL_ALL_NOTES_OFF,
                   7'd0, 2'd3);
      send_message({midi_pca_pkg::CMD_CHAN_AT, 4'd0}, 7'd5, 7'd0, 2'd2);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd65, 7'd80, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_OFF, 4'd0}, 7'd65, 7'd127, 2'd3);
   endtask

   task automatic test_channel_exhaustion();
      configure(16'd2, 16'hFFFF);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd40, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd41, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd42, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_OFF, 4'd0}, 7'd40, 7'd0, 2'd2);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd42, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd0}, 7'd10, 7'd20, 2'd3);
      // zero polyphony and a partial mask
      configure(16'd0, 16'h8001);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd0}, 7'd40, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_NOTE_ON, 4'd1}, 7'd40, 7'd100, 2'd3);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd15}, 7'd10, 7'd20, 2'd3);
      send_message({midi_pca_pkg::CMD_PROGRAM, 4'd15}, 7'd10, 7'd0, 2'd2);
      // values above sixteen clamp
      configure(16'hFFFF, 16'hFFFF);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd3}, 7'd11, 7'd22, 2'd3);
   endtask

   // Hold the output long enough that the request side backs up
   task automatic test_output_backpressure();
      configure(16'd16, 16'hFFFF);
      steady_flow = 1'b1;
      hold_request = 400;
      for (int n = 0; n < 16; n++)
         send_message({midi_pca_pkg::CMD_NOTE_ON, 4'(n)}, 7'(30 + n), 7'(n + 1), 2'd3);
      send_message({midi_pca_pkg::CMD_CONTROL, 4'd0}, 7'd64, 7'd127, 2'd3);
      send_message({midi_pca_pkg::CMD_CHAN_AT, 4'd0}, 7'd77, 7'd0, 2'd2);
      steady_flow = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] poly_set [6];
      logic [CSR_DATA_W-1:0] mask_set [6];
      poly_set = '{16'd16, 16'd4, 16'd31, 16'd1, 16'd2, 16'd0};
      mask_set = '{16'hFFFF, 16'h5A5A, 16'($urandom_range(1, 65535)), 16'hFFFF,
                   16'h00FF, 16'hFFFF};
      for (int p = 0; p < 6; p++) begin
         configure(poly_set[p], mask_set[p]);
         steady_flow = (p == 3);
         for (int i = 0; i < 16; i++) send_random_message();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_status_byte <= '0;
      req_data_one    <= '0;
      req_data_two    <= '0;
      req_byte_count  <= '0;
      csr_we          <= 1'b0;
      csr_index       <= 1'b0;
      csr_wdata       <= '0;
      poly_limit  = CHANNEL_TOTAL;
      listen_mask = '0;
      clear_note_map();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_state();
      test_directed_cases();
      test_channel_exhaustion();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
